FILE: sv/kron_pkg.sv
// ----------------------------------------------------------------------------
// kron_pkg: shared types and constants for the binary Kronecker symbol block
// Word widths, symbol codes, the mod-8 sign table and the control/status
// structs between the top level and the sequencer.
// ----------------------------------------------------------------------------
package kron_pkg;

  // Width of the argument fields on the ports
  localparam int FIELD_W = 32;
  // Width of the arithmetic: inputs are read as their low WIDTH bits,
  // sign-extended from bit WIDTH-1
  localparam int WIDTH   = 32;
  localparam int CNT_W   = $clog2(WIDTH);

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic [WIDTH-1:0]          word_t;
  typedef logic [WIDTH:0]            ext_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic signed [1:0]         sym_t;

  localparam sym_t SYM_ZERO = 2'sb00;
  localparam sym_t SYM_POS  = 2'sb01;
  localparam sym_t SYM_NEG  = 2'sb11;

  // (2/n) by n mod 8
  localparam sym_t MOD8_SIGN [8] = '{SYM_ZERO, SYM_POS, SYM_ZERO, SYM_NEG,
                                     SYM_ZERO, SYM_NEG, SYM_ZERO, SYM_POS};

  // True when (2/n) is -1 for the low three bits of n
  function automatic logic mod8_flip(input logic [2:0] low3);
    return MOD8_SIGN[low3] == SYM_NEG;
  endfunction

  typedef struct packed {
    logic start;  // request accepted this cycle
    logic take;   // result moves into the output register
  } kron_ctl_t;

  typedef struct packed {
    logic idle;   // sequencer can take a request
    logic done;   // result waiting in the sequencer
    sym_t symbol;
  } kron_sts_t;

endpackage

FILE: sv/kron_if.sv
// ----------------------------------------------------------------------------
// kron_if: request and result channels of the Kronecker symbol block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface kron_in_if;
  import kron_pkg::*;

  logic   valid;
  logic   ready;
  field_t top_value;
  field_t bottom_value;

  modport source (output valid, output top_value, output bottom_value, input ready);
  modport sink   (input valid, input top_value, input bottom_value, output ready);
endinterface

interface kron_out_if;
  import kron_pkg::*;

  logic valid;
  logic ready;
  sym_t symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

FILE: sv/kronecker_symbol_binary.sv
// ----------------------------------------------------------------------------
// kronecker_symbol_binary: Kronecker symbol (a/b) by the binary algorithm
// Returns -1, 0 or 1 for a signed pair, one result per request.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                         transfer
//   in_ch    sink       top_value (a), bottom_value (b)  valid && ready
//   out_ch   source     symbol (2-bit signed)            valid && ready
//
// When b is zero or both arguments are even, a request goes straight from idle
// to done and back to idle. Otherwise it passes through the strip of the twos
// of b, the bit-serial modulo reduction over WIDTH bits, one fix-up step, the
// loop on the shared compare-subtract unit, then done and idle.
// in_ch.ready is high only while the sequencer is idle; one request at a time.
// The output register holds a finished result while out_ch stalls, and the
// next request is accepted meanwhile. Reset is synchronous, active low, and
// clears only control state.
// ----------------------------------------------------------------------------
module kronecker_symbol_binary (
  input  logic       clk,
  input  logic       rst_n,
  kron_in_if.sink    in_ch,
  kron_out_if.source out_ch
);
  import kron_pkg::*;

  kron_ctl_t ctl;
  kron_sts_t sts;
  logic      out_valid_r, out_valid_nxt;
  sym_t      out_sym_r;

  kron_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .top_value    (in_ch.top_value),
    .bottom_value (in_ch.bottom_value),
    .sts          (sts)
  );

  // Accept a request whenever the sequencer is idle
  assign in_ch.ready = sts.idle;

  // Move the result out when the output register is empty or draining
  always_comb begin
    ctl.start = in_ch.valid & sts.idle;
    ctl.take  = sts.done & (~out_valid_r | out_ch.ready);
  end

  // Hold the output until the sink takes it; load a new result on take
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      out_sym_r <= sts.symbol;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.symbol = out_sym_r;

endmodule

FILE: sv/kron_alu.sv
// ----------------------------------------------------------------------------
// kron_alu: shared compare and subtract unit
// Compares x with y and returns the magnitude of their difference.
// ----------------------------------------------------------------------------
module kron_alu (
  input  kron_pkg::ext_t op_x,
  input  kron_pkg::ext_t op_y,
  output logic           lt,
  output kron_pkg::ext_t diff
);
  import kron_pkg::*;

  ext_t big;
  ext_t sml;

  always_comb begin
    lt   = op_x < op_y;
    big  = lt ? op_y : op_x;
    sml  = lt ? op_x : op_y;
    diff = big - sml;
  end

endmodule

FILE: sv/kron_seq.sv
// ----------------------------------------------------------------------------
// kron_seq: sequencer for the binary Kronecker symbol
// Strips twos from b, reduces a modulo the odd part of |b| one bit per cycle, then runs the
// strip/reciprocity/subtract loop on the shared compare-subtract unit.
// ----------------------------------------------------------------------------
module kron_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  kron_pkg::kron_ctl_t ctl,
  input  kron_pkg::field_t    top_value,
  input  kron_pkg::field_t    bottom_value,
  output kron_pkg::kron_sts_t sts
);
  import kron_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STRIP = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_FIX   = 3'd3;
  localparam logic [2:0] S_LOOP  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  word_t      a_r, a_nxt;        // remainder, then loop value A
  word_t      b_r, b_nxt;        // loop value B
  word_t      num_r, num_nxt;    // |a|, shifted out MSB first during reduction
  cnt_t       cnt_r, cnt_nxt;
  logic [2:0] alow_r, alow_nxt;
  logic       an_r, an_nxt;
  logic       v_r, v_nxt;        // odd count of stripped twos
  logic       neg_r, neg_nxt;    // accumulated sign
  sym_t       sym_r, sym_nxt;

  word_t aw, bw, amag, bmag;
  logic  an, bn;
  ext_t  op_x, op_y, diff;
  logic  lt, flip;

  kron_alu u_alu (
    .op_x (op_x),
    .op_y (op_y),
    .lt   (lt),
    .diff (diff)
  );

  // Argument decode
  always_comb begin
    aw   = word_t'(top_value);
    bw   = word_t'(bottom_value);
    an   = aw[WIDTH-1];
    bn   = bw[WIDTH-1];
    amag = an ? word_t'(0) - aw : aw;
    bmag = bn ? word_t'(0) - bw : bw;
  end

  // Operand select for the shared unit
  always_comb begin
    case (state_r)
      S_MOD: begin
        op_x = {a_r, num_r[WIDTH-1]};
        op_y = {1'b0, b_r};
      end
      S_FIX: begin
        op_x = {1'b0, b_r};
        op_y = {1'b0, a_r};
      end
      default: begin
        op_x = {1'b0, a_r};
        op_y = {1'b0, b_r};
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    alow_nxt  = alow_r;
    an_nxt    = an_r;
    v_nxt     = v_r;
    neg_nxt   = neg_r;
    sym_nxt   = sym_r;
    flip      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          b_nxt    = bmag;
          num_nxt  = amag;
          an_nxt   = an;
          alow_nxt = aw[2:0];
          neg_nxt  = an & bn;
          v_nxt    = 1'b0;
          if (bmag == word_t'(0)) begin
            sym_nxt   = (amag == word_t'(1)) ? SYM_POS : SYM_ZERO;
            state_nxt = S_DONE;
          end else if (!aw[0] && !bw[0]) begin
            sym_nxt   = SYM_ZERO;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_STRIP;
          end
        end
      end
      S_STRIP: begin
        if (!b_r[0]) begin
          b_nxt = b_r >> 1;
          v_nxt = ~v_r;
        end else begin
          neg_nxt   = neg_r ^ (v_r & mod8_flip(alow_r));
          v_nxt     = 1'b0;
          a_nxt     = word_t'(0);
          cnt_nxt   = cnt_t'(WIDTH - 1);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        // restoring step: shift in the next dividend bit, subtract when it fits
        a_nxt   = lt ? op_x[WIDTH-1:0] : diff[WIDTH-1:0];
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - cnt_t'(1);
        if (cnt_r == cnt_t'(0)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (an_r && (a_r != word_t'(0))) begin
          a_nxt = diff[WIDTH-1:0];
        end
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (a_r == word_t'(0)) begin
          sym_nxt   = (b_r == word_t'(1)) ? (neg_r ? SYM_NEG : SYM_POS) : SYM_ZERO;
          state_nxt = S_DONE;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
          v_nxt = ~v_r;
        end else begin
          flip  = v_r & mod8_flip(b_r[2:0]);
          v_nxt = 1'b0;
          a_nxt = diff[WIDTH-1:0];
          if (lt) begin
            // reciprocity swap
            b_nxt = a_r;
            flip  = flip ^ (a_r[1] & b_r[1]);
          end
          neg_nxt = neg_r ^ flip;
        end
      end
      S_DONE: begin
        if (ctl.take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    num_r  <= num_nxt;
    cnt_r  <= cnt_nxt;
    alow_r <= alow_nxt;
    an_r   <= an_nxt;
    v_r    <= v_nxt;
    neg_r  <= neg_nxt;
    sym_r  <= sym_nxt;
  end

  always_comb begin
    sts.idle   = state_r == S_IDLE;
    sts.done   = state_r == S_DONE;
    sts.symbol = sym_r;
  end

  a_rem_below_b: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_FIX) |-> a_r < b_r)
    else $error("remainder not below divisor");

  a_b_odd_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOP) |-> b_r[0])
    else $error("loop divisor is even");

  a_take_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |-> (state_r == S_DONE) && (sym_r != 2'sb10))
    else $error("result taken while not ready or invalid code");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> (state_r != S_IDLE) && (state_r != S_MOD))
    else $error("request did not leave idle");

endmodule
